// File: rtl/lpam_pkg.sv
package lpam_pkg;

  typedef logic [3:0] step_t;

  localparam step_t StChk0    = 4'd0;
  localparam step_t StEven    = 4'd1;
  localparam step_t StInitD   = 4'd2;
  localparam step_t StDivGo   = 4'd3;
  localparam step_t StDivWait = 4'd4;
  localparam step_t StCmpQ    = 4'd5;
  localparam step_t StCmpR    = 4'd6;
  localparam step_t StIncD    = 4'd7;
  localparam step_t StDecV    = 4'd8;
  localparam step_t StDone    = 4'd9;

  typedef enum logic [2:0] {
    ActNone  = 3'd0,
    ActInitD = 3'd1,
    ActDivGo = 3'd2,
    ActIncD  = 3'd3,
    ActDecV  = 3'd4,
    ActDone  = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    CndNever   = 3'd0,
    CndAlways  = 3'd1,
    CndVZero   = 3'd2,
    CndVEven   = 3'd3,
    CndDivBusy = 3'd4,
    CndDGtQ    = 3'd5,
    CndRZero   = 3'd6
  } cnd_e;

  typedef struct packed {
    act_e  act;
    cnd_e  cnd;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic v_zero;
    logic v_even;
    logic div_busy;
    logic d_gt_q;
    logic r_zero;
  } flags_t;

  // control store: jump to target when condition holds, else fall through
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      StChk0:    w = '{act: ActNone,  cnd: CndVZero,   target: StDone};
      StEven:    w = '{act: ActNone,  cnd: CndVEven,   target: StDecV};
      StInitD:   w = '{act: ActInitD, cnd: CndNever,   target: StChk0};
      StDivGo:   w = '{act: ActDivGo, cnd: CndNever,   target: StChk0};
      StDivWait: w = '{act: ActNone,  cnd: CndDivBusy, target: StDivWait};
      StCmpQ:    w = '{act: ActNone,  cnd: CndDGtQ,    target: StDone};
      StCmpR:    w = '{act: ActNone,  cnd: CndRZero,   target: StDecV};
      StIncD:    w = '{act: ActIncD,  cnd: CndAlways,  target: StDivGo};
      StDecV:    w = '{act: ActDecV,  cnd: CndAlways,  target: StChk0};
      StDone:    w = '{act: ActDone,  cnd: CndNever,   target: StDone};
      default:   w = '{act: ActDone,  cnd: CndNever,   target: StDone};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/largest_prime_at_most.sv
// Largest value not above n that passes trial division (1 counts as prime).
// Command port: a transaction is taken on a clock edge with start high and
// busy low; busy rises on the next cycle and stays high until the result.
// The result (prime_found_o, input_is_prime_o) is shown for one cycle with
// result_valid_o high; the receiver cannot stall, so it must take it then.
// busy falls in the same cycle that result_valid_o rises, so a new start
// may be taken while the result is being shown.
// Latency is data dependent. A microcoded sequencer walks candidates v from
// n downward; odd v and v = 2 get odd trial divisors d from 3 upward while
// d <= v / d. Each divisor costs one pass of the shared bit-serial divider,
// and each candidate adds sequencer steps of overhead. n = 0 goes straight
// to the result without a division; a prime near 2^32 takes one pass per
// odd divisor up to about its square root, plus the composites scanned
// across the prime gap, each stopping at its smallest divisor.
// Nothing is stored between transactions. Reset clears busy and the strobe;
// a transaction in flight is dropped.
module largest_prime_at_most #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] n_value_i,
  output logic        result_valid_o,
  output logic [31:0] prime_found_o,
  output logic        input_is_prime_o
);

  logic [63:0]            n_64, v_64;
  logic [VALUE_WIDTH-1:0] n_w;
  logic [VALUE_WIDTH-1:0] n_q, v_q, d_q;
  logic [VALUE_WIDTH-1:0] quo, rem;
  logic                   div_busy, div_go, accept;
  lpam_pkg::act_e         act;
  lpam_pkg::flags_t       flags;
  logic                   valid_q;
  logic [31:0]            prime_q;
  logic                   flag_q;

  assign n_64   = {32'd0, n_value_i};
  assign n_w    = n_64[VALUE_WIDTH-1:0];
  assign v_64   = 64'(v_q);
  assign accept = start && !busy;
  assign div_go = (act == lpam_pkg::ActDivGo);

  always_comb begin
    flags.v_zero   = (v_q == '0);
    flags.v_even   = !v_q[0] && (v_q[VALUE_WIDTH-1:2] != '0);
    flags.div_busy = div_busy;
    flags.d_gt_q   = (d_q > quo);
    flags.r_zero   = (rem == '0);
  end

  lpam_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (start),
    .flags_i (flags),
    .act_o   (act),
    .busy_o  (busy)
  );

  lpam_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (v_q),
    .divisor_i  (d_q),
    .busy_o     (div_busy),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q <= n_w;
      v_q <= n_w;
    end else begin
      case (act)
        lpam_pkg::ActInitD: d_q <= VALUE_WIDTH'(3);
        lpam_pkg::ActIncD:  d_q <= d_q + VALUE_WIDTH'(2);
        lpam_pkg::ActDecV:  v_q <= v_q - 1'b1;
        lpam_pkg::ActDone: begin
          prime_q <= v_64[31:0];
          flag_q  <= (v_q == n_q) && (n_q != '0);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (act == lpam_pkg::ActDone);
    end
  end

  assign result_valid_o   = valid_q;
  assign prime_found_o    = prime_q;
  assign input_is_prime_o = flag_q;

endmodule

// File: rtl/lpam_div.sv
module lpam_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] quo_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic [VALUE_WIDTH:0]   shifted, diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_d = diff[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/lpam_seq.sv
module lpam_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  lpam_pkg::flags_t  flags_i,
  output lpam_pkg::act_e    act_o,
  output logic              busy_o
);

  logic             busy_q;
  lpam_pkg::step_t  step_q, step_d;
  lpam_pkg::uword_t uw;
  logic             take;

  always_comb begin
    uw = lpam_pkg::ucode(step_q);
    case (uw.cnd)
      lpam_pkg::CndNever:   take = 1'b0;
      lpam_pkg::CndAlways:  take = 1'b1;
      lpam_pkg::CndVZero:   take = flags_i.v_zero;
      lpam_pkg::CndVEven:   take = flags_i.v_even;
      lpam_pkg::CndDivBusy: take = flags_i.div_busy;
      lpam_pkg::CndDGtQ:    take = flags_i.d_gt_q;
      lpam_pkg::CndRZero:   take = flags_i.r_zero;
      default:              take = 1'b0;
    endcase
    step_d = take ? uw.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= lpam_pkg::StChk0;
    end else if (go_i && !busy_q) begin
      busy_q <= 1'b1;
      step_q <= lpam_pkg::StChk0;
    end else if (busy_q) begin
      if (uw.act == lpam_pkg::ActDone) begin
        busy_q <= 1'b0;
      end
      step_q <= step_d;
    end
  end

  assign act_o  = busy_q ? uw.act : lpam_pkg::ActNone;
  assign busy_o = busy_q;

endmodule

// File: rtl/lpam_checker.sv
module lpam_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [31:0] prime_found_o,
  input logic        input_is_prime_o
);

  a_take_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy did not rise after start");

  a_busy_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o) else $error("busy fell without result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("result shown while busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe repeated");

  a_flag_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && input_is_prime_o |-> prime_found_o != 32'd0)
    else $error("prime flag with zero result");

endmodule

bind largest_prime_at_most lpam_checker u_lpam_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .result_valid_o   (result_valid_o),
  .prime_found_o    (prime_found_o),
  .input_is_prime_o (input_is_prime_o)
);
